>>> sv/integer_to_ascii_digits_unit_assert.svh
// Assertion macros shared by the integer-to-ASCII conversion RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef INTEGER_TO_ASCII_DIGITS_UNIT_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define I2A_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked only outside reset.
`define I2A_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/i2a_pkg.sv
// Package for the integer-to-ASCII conversion unit: sequencer states,
// digit register commands and ASCII constants. Depends on nothing.
package i2a_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} i2a_state_t;

	// Commands from the sequencer to the digit register.
	typedef struct packed {
		logic load;       // load a new transaction
		logic load_hex;   // with load: take the word as hex nibbles, else clear
		logic dabble;     // one shift-and-add-3 step with bit_in entering
		logic bit_in;     // next magnitude bit, most significant first
		logic next_digit; // drop the top digit, move the rest up one place
	} i2a_digit_ctrl_t;

	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_MINUS   = 8'h2d;

	function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
		logic [7:0] code;
		if (d < 4'd10) begin
			code = ASCII_ZERO + 8'(d);
		end else begin
			code = ASCII_LOWER_A + 8'(d - 4'd10);
		end
		return code;
	endfunction

endpackage

>>> sv/integer_to_ascii_digits_unit.sv
// Top level of the integer-to-ASCII conversion unit: sequencer, magnitude
// register and output strobe. Uses i2a_pkg, i2a_digit_reg and the assert header.
//
//  channel   signals                              handshake
//  input     value, hex_mode, signed_mode         taken when start && !busy
//  output    char_code, last_char                 strobe, one per character
//
// The word is loaded into the digit register at the accepting edge. A hex transaction then
// steps through the NDIG digit places (10 at 32 bits), one per leading zero digit skipped and
// one per character. A decimal transaction first runs bit-serial binary to BCD conversion
// (one magnitude bit per cycle) and then emits a minus sign if the word is negative.
// busy is high from the cycle after acceptance until the last character's cycle ends.
// Reset clears the sequencer only; there is no clearing pass and no stall from the receiver.
`include "integer_to_ascii_digits_unit_assert.svh"

module integer_to_ascii_digits_unit #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic                   hex_mode,
	input  logic                   signed_mode,
	output logic                   strobe,
	output logic [7:0]             char_code,
	output logic                   last_char
);
	import i2a_pkg::*;

	// Decimal digits of the widest word; always at least the hex digit count.
	localparam int NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BW   = $clog2(VALUE_WIDTH + 1);
	localparam int RW   = $clog2(NDIG + 1);

	i2a_state_t       state_q, state_d;
	i2a_digit_ctrl_t  ctrl;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic             neg_q;
	logic [BW-1:0]    bits_q;
	logic [RW-1:0]    rem_q;
	logic [3:0]       top_digit;
	logic             accept;
	logic             neg_in;
	logic             rem_is_one;
	logic             skip_lead;

	assign accept     = start && !busy;
	assign neg_in     = !hex_mode && signed_mode && value[VALUE_WIDTH-1];
	assign rem_is_one = (rem_q == RW'(1));
	// A leading zero is dropped unless it is the only digit left.
	assign skip_lead  = (top_digit == 4'd0) && !rem_is_one;
	assign busy       = (state_q != ST_IDLE);

	i2a_digit_reg #(
		.VW   (VALUE_WIDTH),
		.NDIG (NDIG)
	) u_digits (
		.clk        (clk),
		.ctrl       (ctrl),
		.load_value (value),
		.top_digit  (top_digit)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = hex_mode ? ST_SKIP : ST_CONVERT;
				end
			end
			ST_CONVERT: begin
				if (bits_q == BW'(1)) begin
					state_d = neg_q ? ST_SIGN : ST_SKIP;
				end
			end
			ST_SIGN: begin
				state_d = ST_SKIP;
			end
			ST_SKIP: begin
				if (!skip_lead) begin
					state_d = rem_is_one ? ST_IDLE : ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (rem_is_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs and digit register commands.
	always_comb begin
		ctrl       = '0;
		ctrl.bit_in = mag_q[VALUE_WIDTH-1];
		strobe     = 1'b0;
		char_code  = 8'h00;
		last_char  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ctrl.load     = accept;
				ctrl.load_hex = hex_mode;
			end
			ST_CONVERT: begin
				ctrl.dabble = 1'b1;
			end
			ST_SIGN: begin
				strobe    = 1'b1;
				char_code = ASCII_MINUS;
			end
			ST_SKIP: begin
				if (skip_lead) begin
					ctrl.next_digit = 1'b1;
				end else begin
					strobe          = 1'b1;
					char_code       = digit_to_ascii(top_digit);
					last_char       = rem_is_one;
					ctrl.next_digit = !rem_is_one;
				end
			end
			ST_EMIT: begin
				strobe          = 1'b1;
				char_code       = digit_to_ascii(top_digit);
				last_char       = rem_is_one;
				ctrl.next_digit = !rem_is_one;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bits_q  <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				bits_q <= BW'(VALUE_WIDTH);
				rem_q  <= RW'(NDIG);
			end else begin
				if (state_q == ST_CONVERT) begin
					bits_q <= bits_q - BW'(1);
				end
				if (ctrl.next_digit) begin
					rem_q <= rem_q - RW'(1);
				end
			end
		end
	end

	// Magnitude register: negated at acceptance when the signed word is negative, then shifted out MSB first.
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q <= neg_in ? (~value + VALUE_WIDTH'(1)) : value;
			neg_q <= neg_in;
		end else if (state_q == ST_CONVERT) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	`I2A_ASSERT_NOW(a_strobe_busy, strobe, busy, "character strobed while not busy")
	`I2A_ASSERT_NOW(a_last_strobe, last_char, strobe, "last_char set without strobe")
	`I2A_ASSERT_NEXT(a_last_ends, strobe && last_char, !busy, "busy after final character")
	`I2A_ASSERT_NEXT(a_accept_busy, accept, busy, "not busy after accepting a transaction")
	`I2A_ASSERT_NOW(a_convert_quiet, state_q == ST_CONVERT, !strobe, "strobe during conversion")

endmodule

>>> sv/i2a_digit_reg.sv
// Digit register of the integer-to-ASCII unit: a row of 4-bit digits that
// runs shift-and-add-3 binary to BCD conversion and shifts digits out. Uses i2a_pkg.
module i2a_digit_reg #(
	parameter int VW   = 32,
	parameter int NDIG = 10
) (
	input  logic                     clk,
	input  i2a_pkg::i2a_digit_ctrl_t ctrl,
	input  logic [VW-1:0]            load_value,
	output logic [3:0]               top_digit
);
	import i2a_pkg::*;

	localparam int DW = 4 * NDIG;

	logic [DW-1:0] digits_q;
	logic [DW-1:0] adj;

	// Each digit lane is corrected on its own before the shift.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (digits_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = digits_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			digits_q <= ctrl.load_hex ? DW'(load_value) : '0;
		end else if (ctrl.dabble) begin
			digits_q <= {adj[DW-2:0], ctrl.bit_in};
		end else if (ctrl.next_digit) begin
			digits_q <= {digits_q[DW-5:0], 4'h0};
		end
	end

	assign top_digit = digits_q[DW-1 -: 4];

endmodule

>>> verif/integer_to_ascii_digits_unit_tb.sv
// Self-checking testbench for integer_to_ascii_digits_unit: converts words to ASCII digit streams.
// Depends on the unit's RTL, the i2a_pkg package and the assertion header that the RTL includes.
// Stands alone: the stimulus is generated and the expected characters are predicted in this file.
module integer_to_ascii_digits_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VALUE_WIDTH = 32;
	// When no more than this many words are left to send, the driver stops idling.
	localparam int TAIL_ITEMS = 60;
	localparam int RANDOM_ITEMS = 420;
	// The worst case is one full decimal conversion plus the longest idle gap per
	// transaction. For roughly 450 transactions this limit leaves a wide margin.
	localparam int CYCLE_LIMIT = 200000;
	// After the last expected character, wait longer than one full decimal conversion.
	localparam int DRAIN_CYCLES = 64;
	// Digit glyphs, first character in the top byte.
	localparam logic [8*16-1:0] DIGIT_GLYPHS = "0123456789abcdef";

	// One word to convert, as presented on the input ports.
	typedef struct {
		logic [VALUE_WIDTH-1:0] word;
		logic                   hex;
		logic                   sgn;
	} word_item_t;

	// One predicted character.
	typedef struct {
		logic [7:0] code;
		logic       last;
	} ascii_char_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic [VALUE_WIDTH-1:0] value = '0;
	logic                   hex_mode = 1'b0;
	logic                   signed_mode = 1'b0;
	logic                   busy;
	logic                   strobe;
	logic [7:0]             char_code;
	logic                   last_char;

	// Words waiting to be sent, and the characters still owed by the unit.
	word_item_t  pending_words[$];
	ascii_char_t expected_chars[$];

	// The driver hands each accepted word to the monitor through these registers.
	// They are updated with nonblocking assignments, so the monitor picks the word up
	// on the next edge. The prediction never depends on the order in which the two
	// blocks run at the same edge.
	logic                   taken_valid = 1'b0;
	word_item_t             taken_word;
	word_item_t             next_word;
	int                     idle_left = 0;
	int                     mismatch_count = 0;
	int                     cycle_count = 0;

	integer_to_ascii_digits_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.hex_mode   (hex_mode),
		.signed_mode(signed_mode),
		.strobe     (strobe),
		.char_code  (char_code),
		.last_char  (last_char)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Adds the characters for one word to the end of expected_chars. The digits are
	// peeled off by repeated division, least significant first, so the digit list is
	// built from the front and then read out most significant first. The sign is
	// handled only in signed decimal mode. Negating the most negative word wraps back
	// to itself, and that value read as unsigned is its true magnitude.
	function automatic void predict_chars(input word_item_t w);
		logic [VALUE_WIDTH-1:0] mag;
		logic [VALUE_WIDTH-1:0] base;
		logic [3:0]             digit_list[$];
		ascii_char_t            ch;
		logic [3:0]             d;
		base = w.hex ? VALUE_WIDTH'(16) : VALUE_WIDTH'(10);
		if (!w.hex && w.sgn && w.word[VALUE_WIDTH-1]) begin
			mag = -w.word;
			ch.code = i2a_pkg::ASCII_MINUS;
			ch.last = 1'b0;
			expected_chars.push_back(ch);
		end else begin
			mag = w.word;
		end
		while (mag != '0) begin
			digit_list.push_front(4'(mag % base));
			mag = mag / base;
		end
		// A zero word has no digits left after the loop and prints a single zero.
		if (digit_list.size() == 0) begin
			digit_list.push_back(4'd0);
		end
		foreach (digit_list[i]) begin
			d = digit_list[i];
			ch.code = DIGIT_GLYPHS[8*(15-int'(d)) +: 8];
			ch.last = (i == digit_list.size() - 1);
			expected_chars.push_back(ch);
		end
	endfunction

	task automatic add_word(input logic [VALUE_WIDTH-1:0] w, input logic hex, input logic sgn);
		word_item_t it;
		it.word = w;
		it.hex = hex;
		it.sgn = sgn;
		pending_words.push_back(it);
	endtask

	// Stimulus. A short directed list comes first, then random words.
	initial begin
		logic [VALUE_WIDTH-1:0] pow;
		logic [VALUE_WIDTH-1:0] w;
		int                     k;
		// Zero and all ones, in every mode combination. The signed flag must
		// not matter in hex mode.
		for (int m = 0; m < 4; m++) begin
			add_word('0, m[1], m[0]);
			add_word('1, m[1], m[0]);
		end
		// Most negative word: signed decimal needs its true magnitude, while
		// unsigned decimal and hex read the raw pattern.
		add_word(32'h8000_0000, 1'b0, 1'b1);
		add_word(32'h8000_0000, 1'b0, 1'b0);
		add_word(32'h8000_0000, 1'b1, 1'b1);
		add_word(32'h7fff_ffff, 1'b0, 1'b1);
		add_word(32'h7fff_ffff, 1'b1, 1'b0);
		// Single digits, and the boundaries where a second digit appears.
		add_word(32'd1, 1'b0, 1'b0);
		add_word(32'd9, 1'b0, 1'b0);
		add_word(32'd10, 1'b0, 1'b1);
		add_word(32'd15, 1'b1, 1'b0);
		add_word(32'd16, 1'b1, 1'b0);
		add_word(32'habcd_ef01, 1'b1, 1'b1);
		add_word(32'd999_999_999, 1'b0, 1'b0);
		add_word(32'd1_000_000_000, 1'b0, 1'b0);
		add_word(-32'sd10, 1'b0, 1'b1);

		// Random words. The shapes mix full-range words, shortened words that
		// produce every digit count, words near powers of ten, small negative
		// numbers, and small words up to 99 or zero.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ($urandom_range(0, 5))
				0, 1: w = $urandom;
				2: w = $urandom >> $urandom_range(0, VALUE_WIDTH - 1);
				3: begin
					k = $urandom_range(0, 9);
					pow = 1;
					repeat (k) pow = pow * 10;
					w = pow + $urandom_range(0, 2) - 1;
				end
				4: w = -VALUE_WIDTH'($urandom_range(0, 1000));
				default: w = ($urandom_range(0, 3) == 0) ? '0 : VALUE_WIDTH'($urandom_range(0, 99));
			endcase
			add_word(w, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	end

	// Reset: asserted from time zero and released at a clock edge.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver. A transaction is taken at an edge where start is high and busy is low.
	// Once start is high it stays high until the transaction is taken. Between
	// transactions the driver may insert a random idle burst. Because the next word
	// can go up while busy is still high, or after a gap, start arrives at different
	// points of the previous conversion. Near the end of the stimulus the driver stops
	// idling and sends the words back to back.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start       <= 1'b0;
			value       <= '0;
			hex_mode    <= 1'b0;
			signed_mode <= 1'b0;
			taken_valid <= 1'b0;
			idle_left = 0;
		end else begin
			taken_valid <= start && !busy;
			if (start && !busy) begin
				taken_word.word <= value;
				taken_word.hex  <= hex_mode;
				taken_word.sgn  <= signed_mode;
			end
			// Choose what to present next. If a transaction is still waiting for
			// busy to fall, leave everything as it is.
			if (!start || !busy) begin
				if (idle_left == 0 && pending_words.size() > TAIL_ITEMS
						&& $urandom_range(0, 3) == 0) begin
					idle_left = $urandom_range(1, 16);
				end
				if (idle_left > 0) begin
					idle_left--;
					start <= 1'b0;
				end else if (pending_words.size() > 0) begin
					next_word = pending_words.pop_front();
					start       <= 1'b1;
					value       <= next_word.word;
					hex_mode    <= next_word.hex;
					signed_mode <= next_word.sgn;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor. It first queues the characters predicted for the word that was taken
	// at the previous edge. It then compares any strobed character with the oldest
	// one still owed. A character must never come out at the same edge at which its
	// own word is taken.
	always @(posedge clk) begin
		ascii_char_t want;
		if (arst_n) begin
			if (taken_valid) begin
				predict_chars(taken_word);
			end
			if (strobe) begin
				if (expected_chars.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected character: expected none, actual code %02h last %0b",
						$time, char_code, last_char);
				end else begin
					want = expected_chars.pop_front();
					if (char_code !== want.code) begin
						mismatch_count++;
						$display("%0t: char_code mismatch: expected %02h, actual %02h",
							$time, want.code, char_code);
					end
					if (last_char !== want.last) begin
						mismatch_count++;
						$display("%0t: last_char mismatch: expected %0b, actual %0b",
							$time, want.last, last_char);
					end
				end
			end
		end
	end

	// Watchdog for a hung handshake or a missing last character.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// End of run. The state is polled on the falling edge, when every update made at
	// the rising edge has settled. After all words have been sent and every
	// character has arrived, the run waits a while longer to catch stray strobes.
	initial begin
		@(posedge arst_n);
		@(negedge clk);
		while (pending_words.size() != 0 || start || taken_valid || expected_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && expected_chars.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/i2a_pkg.sv
sv/i2a_digit_reg.sv
sv/integer_to_ascii_digits_unit.sv
verif/integer_to_ascii_digits_unit_tb.sv
